// File: hw/rtl/pfoq_pkg.sv
`timescale 1ns / 1ps

package pfoq_pkg;

    // Number of frame slots in the order list
    localparam int NUM_FRAMES = 64;
    // Frame index width, fixed by the item format
    localparam int FRAME_W    = 6;
    // Address width of the list store
    localparam int ADDR_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    // Width of the entry count, holds 0..NUM_FRAMES
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

    // Operation codes
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_POP    = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Source of the reported frame
    typedef enum logic [1:0] {
        SRC_IN  = 2'd0,
        SRC_RD  = 2'd1,
        SRC_LAT = 2'd2
    } t_src;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       append;
        logic       scan_start;
        logic       scan_step;
        logic       found;
        logic       shift_step;
        logic       finish;
        logic       emit;
        logic [1:0] status;
        t_src       src;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic full;
        logic cmp_vld;
        logic match;
        logic cmp_last;
        logic shift_last;
    } t_dp_stat;

endpackage

// File: hw/rtl/pfoq_ram.sv
`timescale 1ns / 1ps

module pfoq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one word, read one word with registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pfoq_ctrl.sv
`timescale 1ns / 1ps

module pfoq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_kind,
    input  pfoq_pkg::t_dp_stat i_stat,
    output pfoq_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    import pfoq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_cmd cmd;

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.src = SRC_IN;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        KIND_APPEND: begin
                            cmd.emit = 1'b1;
                            if (i_stat.full) begin
                                cmd.status = ST_FULL;
                            end else begin
                                cmd.append = 1'b1;
                                cmd.status = ST_OK;
                            end
                        end
                        KIND_REMOVE, KIND_POP: begin
                            if (i_stat.empty) begin
                                cmd.emit   = 1'b1;
                                cmd.status = ST_EMPTY;
                            end else begin
                                cmd.scan_start = 1'b1;
                                n_state        = S_SCAN;
                            end
                        end
                        default: begin
                            // unused code: drop the item
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (i_stat.cmp_vld && i_stat.match) begin
                    cmd.found = 1'b1;
                    if (i_stat.cmp_last) begin
                        cmd.finish = 1'b1;
                        cmd.emit   = 1'b1;
                        cmd.status = ST_OK;
                        cmd.src    = SRC_RD;
                        n_state    = S_IDLE;
                    end else begin
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.cmp_vld && i_stat.cmp_last) begin
                    cmd.emit   = 1'b1;
                    cmd.status = ST_NOT_FOUND;
                    n_state    = S_IDLE;
                end
            end
            S_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (i_stat.shift_last) begin
                    cmd.finish = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.status = ST_OK;
                    cmd.src    = SRC_LAT;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hw/rtl/pfoq_dp.sv
`timescale 1ns / 1ps

module pfoq_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [1:0]                     i_kind,
    input  logic [pfoq_pkg::FRAME_W-1:0]   i_frame_index,
    input  pfoq_pkg::t_dp_cmd              i_cmd,
    output pfoq_pkg::t_dp_stat             o_stat,
    output logic                           o_valid,
    output logic [pfoq_pkg::FRAME_W-1:0]   o_result_frame,
    output logic [1:0]                     o_status
);

    import pfoq_pkg::*;

    logic [CNT_W-1:0]   r_count,     n_count;
    logic [CNT_W-1:0]   r_ptr,       n_ptr;
    logic [CNT_W-1:0]   r_cmp_pos,   n_cmp_pos;
    logic               r_cmp_vld,   n_cmp_vld;
    logic [CNT_W-1:0]   r_wr_pos,    n_wr_pos;
    logic [FRAME_W-1:0] r_frame,     n_frame;
    logic               r_pop,       n_pop;
    logic [FRAME_W-1:0] r_res_frame, n_res_frame;
    logic               r_out_vld,   n_out_vld;
    logic [FRAME_W-1:0] r_out_frame, n_out_frame;
    logic [1:0]         r_out_status, n_out_status;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [FRAME_W-1:0] ram_wdata;
    logic [FRAME_W-1:0] rd_data;
    logic [FRAME_W-1:0] sel_frame;

    // Steer the single write port: append at tail or move an entry down
    assign ram_we    = i_cmd.append | i_cmd.shift_step;
    assign ram_waddr = i_cmd.append ? r_count[ADDR_W-1:0] : r_wr_pos[ADDR_W-1:0];
    assign ram_wdata = i_cmd.append ? i_frame_index : rd_data;

    pfoq_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (NUM_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    // Report list and walk status
    always_comb begin
        o_stat.empty      = (r_count == '0);
        o_stat.full       = (r_count == CNT_W'(NUM_FRAMES));
        o_stat.cmp_vld    = r_cmp_vld;
        o_stat.match      = r_pop || (rd_data == r_frame);
        o_stat.cmp_last   = ((r_cmp_pos + CNT_W'(1)) == r_count);
        o_stat.shift_last = ((r_wr_pos + CNT_W'(2)) == r_count);
    end

    // Pick the frame to report
    always_comb begin
        case (i_cmd.src)
            SRC_IN:  sel_frame = i_frame_index;
            SRC_RD:  sel_frame = rd_data;
            SRC_LAT: sel_frame = r_res_frame;
            default: sel_frame = '0;
        endcase
    end

    // Next values of the walk and count registers
    always_comb begin
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_cmp_pos    = r_cmp_pos;
        n_cmp_vld    = r_cmp_vld;
        n_wr_pos     = r_wr_pos;
        n_frame      = r_frame;
        n_pop        = r_pop;
        n_res_frame  = r_res_frame;
        n_out_vld    = i_cmd.emit;
        n_out_status = i_cmd.status;
        n_out_frame  = (i_cmd.status == ST_OK) ? sel_frame : '0;

        if (i_cmd.append) begin
            n_count = r_count + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            n_count = r_count - CNT_W'(1);
        end

        // start the walk at the head
        if (i_cmd.scan_start) begin
            n_ptr     = '0;
            n_cmp_vld = 1'b0;
            n_frame   = i_frame_index;
            n_pop     = (i_kind == KIND_POP);
        end

        // compare stage trails the read address, in step with the registered read data
        if (i_cmd.scan_step) begin
            n_ptr     = r_ptr + CNT_W'(1);
            n_cmp_pos = r_ptr;
            n_cmp_vld = 1'b1;
        end

        if (i_cmd.found) begin
            n_wr_pos    = r_cmp_pos;
            n_res_frame = rd_data;
        end

        // close the gap: read one ahead, write one behind
        if (i_cmd.shift_step) begin
            n_ptr    = r_ptr + CNT_W'(1);
            n_wr_pos = r_wr_pos + CNT_W'(1);
        end
    end

    // Hold control state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Advance payload registers
    always_ff @(posedge i_clk) begin
        r_ptr        <= n_ptr;
        r_cmp_pos    <= n_cmp_pos;
        r_wr_pos     <= n_wr_pos;
        r_frame      <= n_frame;
        r_pop        <= n_pop;
        r_res_frame  <= n_res_frame;
        r_out_frame  <= n_out_frame;
        r_out_status <= n_out_status;
    end

    assign o_valid        = r_out_vld;
    assign o_result_frame = r_out_frame;
    assign o_status       = r_out_status;

endmodule

// File: hw/rtl/page_frame_order_queue.sv
`timescale 1ns / 1ps
// Ordered list of page frame indices for FIFO replacement, oldest at the head.
// Request channel: drive i_kind and i_frame_index with start; the item is taken
// at a clock edge where start is high and busy is low. i_kind selects append at
// tail, remove the first matching frame, or pop the head; the unused code is
// dropped with no result.
// Result channel: o_valid is high for one cycle with o_result_frame and
// o_status (ok, empty, not found, full). The frame is zero unless status is ok.
// The receiver cannot stall; every result must be taken in its cycle.
// Timing: append, a refused request or a request on an empty list answers in
// the cycle after acceptance and keeps busy low. Remove and pop walk the list
// in a memory with one read and one write port: first the registered read is
// primed, then entries are compared in order up to the match (or the end of
// the list), then the entries behind the match are moved down to close the
// gap. Busy stays high through the walk, and the result shows in the cycle
// busy falls. One item is in work at a time.
// Reset (synchronous, active low) empties the list; stored words need no
// clearing since only entries below the count are used.
module page_frame_order_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_kind,
    input  logic [pfoq_pkg::FRAME_W-1:0] i_frame_index,
    output logic                         o_valid,
    output logic [pfoq_pkg::FRAME_W-1:0] o_result_frame,
    output logic [1:0]                   o_status
);

    import pfoq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    pfoq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    pfoq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_kind),
        .i_frame_index  (i_frame_index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_result_frame (o_result_frame),
        .o_status       (o_status)
    );

endmodule

// File: hw/rtl/pfoq_checker.sv
`timescale 1ns / 1ps

module pfoq_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_kind,
    input logic [pfoq_pkg::FRAME_W-1:0] i_frame_index,
    input logic                         o_valid,
    input logic [pfoq_pkg::FRAME_W-1:0] o_result_frame,
    input logic [1:0]                   o_status
);

    import pfoq_pkg::*;

    // A refused or failed request reports frame zero
    a_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_result_frame == '0))
        else $error("non-ok result carries a nonzero frame");

    // An append answers in the next cycle with ok or full
    a_append_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == KIND_APPEND) |=>
        (o_valid && !busy && (o_status == ST_OK || o_status == ST_FULL)))
        else $error("append did not answer in one cycle");

    // An unused code produces no result
    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind != KIND_APPEND && i_kind != KIND_REMOVE &&
         i_kind != KIND_POP) |=> !o_valid)
        else $error("unused request produced a result");

    // A walk shows a result in the cycle busy falls
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("walk ended without a result");

    // A walk does not start with a result
    a_walk_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(busy)) |-> (!o_valid && o_status == $past(o_status)
        || !o_valid))
        else $error("result shown as walk started");

endmodule

bind page_frame_order_queue pfoq_checker u_pfoq_checker (.*);
